// ===== design/pdsum_pkg.sv =====
// Shared constants for the proper divisor sum unit.
// No dependencies; imported by pdsum_divider and the top level.
package pdsum_pkg;

    localparam int unsigned DEFAULT_NUM_WIDTH = 32;
    localparam int unsigned SUM_EXTRA_BITS    = 3;

endpackage

// ===== design/pdsum_divider.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on pdsum_pkg for the default operand width.
module pdsum_divider #(
    parameter int unsigned NUM_WIDTH = pdsum_pkg::DEFAULT_NUM_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [NUM_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] quotient,
    output logic [NUM_WIDTH-1:0] remainder
);
    import pdsum_pkg::*;

    localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH + 1);
    localparam logic [CNT_WIDTH-1:0] CNT_LOAD = CNT_WIDTH'(NUM_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_ONE  = CNT_WIDTH'(1);

    logic [NUM_WIDTH-1:0] quo_reg;
    logic [NUM_WIDTH-1:0] rem_reg;
    logic [NUM_WIDTH-1:0] dsr_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [NUM_WIDTH:0]   shifted;
    logic [NUM_WIDTH:0]   diff;
    logic                 fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_WIDTH-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_ONE);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_LOAD;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Payload path: shift one dividend bit in, subtract when it fits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_WIDTH-2:0], fits};
            rem_reg <= fits ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/proper_divisor_sum_perfect_test_unit.sv =====
// Aliquot sum by trial division with a perfect-number flag, top level.
// Depends on pdsum_pkg and pdsum_divider.
//
// One number is taken at a time; in_ready is low until its result has moved
// into the output register, which holds it while the next number is taken.
// The shared serial divider computes n / d and n % d for d = 1, 2, ... while
// d <= n / d. After each divide a step state adds d and its cofactor n / d
// (d alone for d = 1 or d = n / d) to the sum when the remainder is zero.
// Inputs 0 and 1 skip the divider and go straight to the finish state.
// The sum saturates at its all-ones value.
module proper_divisor_sum_perfect_test_unit #(
    parameter int unsigned NUM_WIDTH = pdsum_pkg::DEFAULT_NUM_WIDTH
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [NUM_WIDTH-1:0]                          number,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [NUM_WIDTH+pdsum_pkg::SUM_EXTRA_BITS-1:0] divisor_sum,
    output logic                                          is_perfect
);
    import pdsum_pkg::*;

    localparam int unsigned SUM_WIDTH = NUM_WIDTH + SUM_EXTRA_BITS;
    localparam logic [NUM_WIDTH-1:0] ONE_N = NUM_WIDTH'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_STEP,
        S_FIN
    } state_t;

    state_t               state_reg;
    logic                 start_reg;
    logic [NUM_WIDTH-1:0] n_reg;
    logic [NUM_WIDTH-1:0] d_reg;
    logic [SUM_WIDTH-1:0] sum_reg;
    logic                 out_valid_reg;
    logic [SUM_WIDTH-1:0] out_sum_reg;
    logic                 out_perf_reg;

    logic                 div_done;
    logic [NUM_WIDTH-1:0] div_quo;
    logic [NUM_WIDTH-1:0] div_rem;

    logic                 in_xfer;
    logic                 out_free;
    logic [NUM_WIDTH:0]   add_val;
    logic [SUM_WIDTH:0]   total;
    logic [SUM_WIDTH-1:0] sum_next;

    pdsum_divider #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (d_reg == ONE_N || div_quo == d_reg)
            add_val = {1'b0, d_reg};
        else
            add_val = {1'b0, d_reg} + {1'b0, div_quo};
        total = {1'b0, sum_reg} + (SUM_WIDTH + 1)'(add_val);
        // Saturate on carry out of the sum.
        sum_next = total[SUM_WIDTH] ? '1 : total[SUM_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= (in_xfer && number > ONE_N)
                         || (state_reg == S_STEP && d_reg <= div_quo);
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (number <= ONE_N)
                            state_reg <= S_FIN;
                        else
                            state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (d_reg > div_quo)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_DIV;
                end
                S_FIN:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers and output payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            n_reg   <= number;
            d_reg   <= ONE_N;
            sum_reg <= '0;
        end
        else if (state_reg == S_STEP && d_reg <= div_quo)
        begin
            d_reg <= d_reg + ONE_N;
            if (div_rem == '0)
                sum_reg <= sum_next;
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_sum_reg  <= sum_reg;
            out_perf_reg <= (n_reg != '0) && (SUM_WIDTH'(n_reg) == sum_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign divisor_sum = out_sum_reg;
    assign is_perfect  = out_perf_reg;

endmodule

// ===== sim/proper_divisor_sum_perfect_test_unit_test.sv =====
// Testbench for the proper divisor sum unit: drives numbers, predicts the
// aliquot sum and perfect flag, and checks every output transfer in order.
// Depends on pdsum_pkg and proper_divisor_sum_perfect_test_unit.
`timescale 1ns / 1ps

module proper_divisor_sum_perfect_test_unit_test;
    import pdsum_pkg::*;

    localparam int unsigned NUM_W = DEFAULT_NUM_WIDTH;
    localparam int unsigned SUM_W = NUM_W + SUM_EXTRA_BITS;
    localparam int unsigned RANDOM_ITEMS = 80;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam longint unsigned CYCLE_LIMIT = 20_000_000;

    typedef struct {
        logic [NUM_W-1:0] number;
        logic [SUM_W-1:0] divisor_sum;
        logic             is_perfect;
    } aliquot_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [NUM_W-1:0] number = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [SUM_W-1:0] divisor_sum;
    logic             is_perfect;

    logic [NUM_W-1:0] pending_numbers[$];
    aliquot_result_t  expected_sums[$];
    logic             in_accepted = 1'b0;
    int unsigned      numbers_total = 0;
    int unsigned      numbers_accepted = 0;
    int unsigned      sums_checked = 0;
    int unsigned      perfect_seen = 0;
    int unsigned      error_count = 0;
    longint unsigned  cycle_count = 0;

    proper_divisor_sum_perfect_test_unit #(
        .NUM_WIDTH(NUM_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .number(number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .divisor_sum(divisor_sum),
        .is_perfect(is_perfect)
    );

    always #1 clk = ~clk;

    function automatic aliquot_result_t aliquot_of(logic [NUM_W-1:0] value);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        longint unsigned add;
        longint unsigned total;
        longint unsigned ceiling;
        aliquot_result_t r;
        n = value;
        total = 0;
        ceiling = (64'd1 << SUM_W) - 1;
        if (n > 1)
        begin
            for (d = 1; d <= n / d; d++)
            begin
                if (n % d == 0)
                begin
                    q = n / d;
                    add = (d == 1 || q == d) ? d : d + q;
                    if (add > ceiling - total)
                        total = ceiling;
                    else
                        total += add;
                end
            end
        end
        r.number = value;
        r.divisor_sum = total[SUM_W-1:0];
        r.is_perfect = (n != 0 && n == total);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Driver: advance to the next number once the current one has transferred.
    int unsigned send_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_accepted)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_numbers.size() > 0)
            begin
                number <= pending_numbers.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off early in the run.
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && sums_checked == 3)
        begin
            hold_done = 1;
            hold_left = HOLD_OFF_CYCLES;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Input side: predict the result of each accepted number.
    always @(posedge clk)
    begin
        in_accepted <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            expected_sums.push_back(aliquot_of(number));
            numbers_accepted <= numbers_accepted + 1;
        end
    end

    // Output side: compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        aliquot_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
            begin
                $display("%0t: unexpected result sum=0x%h perfect=%0b",
                         $time, divisor_sum, is_perfect);
                error_count++;
            end
            else
            begin
                want = expected_sums.pop_front();
                if (divisor_sum !== want.divisor_sum)
                begin
                    $display("%0t: number 0x%h divisor_sum expected 0x%h actual 0x%h",
                             $time, want.number, want.divisor_sum, divisor_sum);
                    error_count++;
                end
                if (is_perfect !== want.is_perfect)
                begin
                    $display("%0t: number 0x%h is_perfect expected %0b actual %0b",
                             $time, want.number, want.is_perfect, is_perfect);
                    error_count++;
                end
                if (want.is_perfect)
                    perfect_seen++;
            end
            sums_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_sums.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [NUM_W-1:0] directed[$];
        int unsigned      roll;
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd28, 32'd12,
                     32'd30, 32'd49, 32'd97, 32'd100, 32'd120, 32'd496,
                     32'd1023, 32'd1024, 32'd4095, 32'd4096, 32'd8128,
                     32'd65535, 32'd65536, 32'd33550336, 32'hFFFF_FFFF};
        foreach (directed[i])
            pending_numbers.push_back(directed[i]);
        repeat (RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                pending_numbers.push_back($urandom_range(0, 4095));
            else if (roll < 97)
                pending_numbers.push_back($urandom_range(0, 32'h3_FFFF));
            else
                pending_numbers.push_back($urandom_range(0, 32'hFF_FFFF));
        end
        numbers_total = pending_numbers.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (numbers_accepted != numbers_total || expected_sums.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        $display("Checked %0d divisor sums, %0d of them perfect, inputs from 0 to 0x%h",
                 sums_checked, perfect_seen, 32'hFFFF_FFFF);
        $display("Input stalled behind a %0d-cycle output hold-off; %0d mismatches",
                 HOLD_OFF_CYCLES, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pdsum_pkg.sv
design/pdsum_divider.sv
design/proper_divisor_sum_perfect_test_unit.sv
sim/proper_divisor_sum_perfect_test_unit_test.sv
